// ----- rtl/core/tcp_passive_handshake_engine_unit_macros.svh -----
// Assertion macros for the handshake engine checker
`ifndef TCP_PASSIVE_HANDSHAKE_ENGINE_UNIT_MACROS_SVH
`define TCP_PASSIVE_HANDSHAKE_ENGINE_UNIT_MACROS_SVH
// implication checked every clock, off during reset
`define TPH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tph assertion failed");
// implication checked every clock, also during reset
`define TPH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tph assertion failed");
`endif

// ----- rtl/core/tph_pkg.sv -----
// Shared types and constants for the passive TCP handshake engine
package tph_pkg;
  localparam int unsigned TableEntriesDef = 8;
  localparam logic [15:0] ListenPortRst = 16'd8080;
  localparam logic ListenEnableRst = 1'b1;

  localparam logic [7:0] FlFin = 8'h01;
  localparam logic [7:0] FlSyn = 8'h02;
  localparam logic [7:0] FlRst = 8'h04;
  localparam logic [7:0] FlAck = 8'h10;

  typedef enum logic [2:0] {
    StClosed = 3'd0,
    StListen = 3'd1,
    StSynRcvd = 3'd2,
    StFinWait1 = 3'd3,
    StFinWait2 = 3'd4
  } conn_state_e;

  typedef enum logic [0:0] {
    CfgListenPort = 1'b0,
    CfgListenEnable = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CtlIdle,
    CtlScan,
    CtlDecide,
    CtlOut
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture segment, start scan at entry 0
    logic scan_step;  // compare current entry, advance
    logic commit;     // apply table update and build reply
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic has_reply;
  } dp_sts_t;
endpackage

// ----- rtl/core/tph_datapath.sv -----
// Connection table, scan logic and reply register
module tph_datapath #(
  parameter int unsigned TableEntries = tph_pkg::TableEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tph_pkg::dp_cmd_t cmd_i,
  output tph_pkg::dp_sts_t sts_o,
  input  logic [15:0] listen_port_i,
  input  logic listen_enable_i,
  input  logic [31:0] remote_ip_i,
  input  logic [31:0] local_ip_i,
  input  logic [15:0] remote_port_i,
  input  logic [15:0] local_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] peer_window_i,
  input  logic [7:0] flags_i,
  input  logic checksum_good_i,
  input  logic [31:0] initial_seq_i,
  output logic [31:0] reply_src_ip_o,
  output logic [31:0] reply_dst_ip_o,
  output logic [15:0] reply_src_port_o,
  output logic [15:0] reply_dst_port_o,
  output logic [31:0] reply_seq_o,
  output logic [31:0] reply_ack_o,
  output logic [7:0] reply_flags_o,
  output logic [15:0] reply_window_o,
  output logic [2:0] new_state_o
);
  import tph_pkg::*;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [TableEntries-1:0] valid_q;
  conn_state_e st_q [TableEntries];
  logic [31:0] lip_q [TableEntries];
  logic [31:0] rip_q [TableEntries];
  logic [15:0] lport_q [TableEntries];
  logic [15:0] rport_q [TableEntries];
  logic [31:0] una_q [TableEntries];
  logic [31:0] nxt_q [TableEntries];
  logic [15:0] wnd_q [TableEntries];

  // captured segment
  logic [31:0] s_rip_q, s_lip_q, s_seq_q, s_ack_q, s_isn_q;
  logic [15:0] s_rport_q, s_lport_q, s_wnd_q;
  logic [7:0] s_fl_q;
  logic s_good_q, s_listen_q;

  logic [CntW-1:0] cnt_q;
  logic hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;

  logic [IdxW-1:0] cur;
  logic cur_match;
  assign cur = cnt_q[IdxW-1:0];
  assign cur_match = valid_q[cur] && lip_q[cur] == s_lip_q && rip_q[cur] == s_rip_q
                     && lport_q[cur] == s_lport_q && rport_q[cur] == s_rport_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cnt_q <= cnt_q + 1'b1;
      if (!hit_q && cur_match) begin
        hit_q <= 1'b1;
        hit_idx_q <= cur;
      end
      if (!free_q && !valid_q[cur]) begin
        free_q <= 1'b1;
        free_idx_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_rip_q <= remote_ip_i;
      s_lip_q <= local_ip_i;
      s_rport_q <= remote_port_i;
      s_lport_q <= local_port_i;
      s_seq_q <= seq_number_i;
      s_ack_q <= ack_number_i;
      s_wnd_q <= peer_window_i;
      s_fl_q <= flags_i;
      s_good_q <= checksum_good_i;
      s_isn_q <= initial_seq_i;
      s_listen_q <= listen_enable_i && (local_port_i == listen_port_i);
    end
  end

  assign sts_o.scan_done = (cnt_q == CntW'(TableEntries - 1)) || !s_listen_q
                           || !s_good_q;

  // decision on captured segment and scan result
  logic [IdxW-1:0] e;
  logic use_ok;
  conn_state_e est;
  logic [31:0] nxt_d, una_d;
  conn_state_e st_d;
  logic upd, emit, drop_entry;
  logic [7:0] rfl;
  always_comb begin
    e = hit_q ? hit_idx_q : free_idx_q;
    use_ok = hit_q || free_q;
    est = hit_q ? st_q[e] : StListen;
    nxt_d = s_seq_q + 32'd1;
    una_d = s_ack_q;
    st_d = est;
    upd = 1'b0;
    emit = 1'b0;
    drop_entry = 1'b0;
    rfl = FlAck;
    case (est)
      StListen: if (s_fl_q == FlSyn) begin
        st_d = StSynRcvd; una_d = s_isn_q; upd = 1'b1; emit = 1'b1;
        rfl = FlSyn | FlAck;
      end
      StSynRcvd: if (s_fl_q == FlAck) begin
        st_d = StFinWait1; nxt_d = s_seq_q; upd = 1'b1; emit = 1'b1;
        rfl = FlFin | FlAck;
      end
      StFinWait1: if (s_fl_q == FlAck) st_d = StFinWait2;
      StFinWait2: if (s_fl_q == (FlFin | FlAck)) begin
        st_d = StClosed; upd = 1'b1; emit = 1'b1; rfl = FlAck;
      end
      StClosed: drop_entry = 1'b1;
      default: ;
    endcase
  end

  assign sts_o.has_reply = s_good_q && (!s_listen_q || (use_ok && emit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < TableEntries; i++) st_q[i] <= StClosed;
    end else if (cmd_i.commit && s_good_q && s_listen_q && use_ok) begin
      valid_q[e] <= !drop_entry;
      st_q[e] <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && s_good_q && s_listen_q && use_ok) begin
      if (!hit_q) begin
        lip_q[e] <= s_lip_q;
        rip_q[e] <= s_rip_q;
        lport_q[e] <= s_lport_q;
        rport_q[e] <= s_rport_q;
      end
      if (upd) begin
        una_q[e] <= una_d;
        nxt_q[e] <= nxt_d;
        wnd_q[e] <= s_wnd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!s_listen_q) begin
        reply_src_ip_o <= s_lip_q;
        reply_dst_ip_o <= s_rip_q;
        reply_src_port_o <= s_lport_q;
        reply_dst_port_o <= s_rport_q;
        reply_seq_o <= s_ack_q;
        reply_ack_o <= s_seq_q + 32'd1;
        reply_flags_o <= FlRst | FlAck;
        reply_window_o <= '0;
        new_state_o <= StClosed;
      end else begin
        reply_src_ip_o <= s_lip_q;
        reply_dst_ip_o <= s_rip_q;
        reply_src_port_o <= s_lport_q;
        reply_dst_port_o <= s_rport_q;
        reply_seq_o <= una_d;
        reply_ack_o <= nxt_d;
        reply_flags_o <= rfl;
        reply_window_o <= s_wnd_q;
        new_state_o <= st_d;
      end
    end
  end
endmodule

// ----- rtl/core/tph_ctrl.sv -----
// Sequencing state machine: capture, scan, decide, deliver
module tph_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic seg_valid_i,
  output logic seg_stall_o,
  output logic reply_valid_o,
  input  logic reply_stall_i,
  output tph_pkg::dp_cmd_t cmd_o,
  input  tph_pkg::dp_sts_t sts_i
);
  import tph_pkg::*;
  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CtlIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CtlIdle: if (seg_valid_i) state_d = CtlScan;
      CtlScan: if (sts_i.scan_done) state_d = CtlDecide;
      CtlDecide: state_d = sts_i.has_reply ? CtlOut : CtlIdle;
      CtlOut: if (!reply_stall_i) state_d = CtlIdle;
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    seg_stall_o = 1'b1;
    reply_valid_o = 1'b0;
    case (state_q)
      CtlIdle: begin
        seg_stall_o = 1'b0;
        cmd_o.load = seg_valid_i;
      end
      CtlScan: cmd_o.scan_step = 1'b1;
      CtlDecide: cmd_o.commit = 1'b1;
      CtlOut: reply_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- rtl/core/tcp_passive_handshake_engine_unit.sv -----
// Top level of the passive TCP handshake engine
//  channel  | direction | handshake
//  segment  | in        | seg_valid_i / seg_stall_o
//  reply    | out       | reply_valid_o / reply_stall_i
//  config   | in        | cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
// A listening segment is accepted, the table is scanned serially, one entry
// per cycle, then a decide state follows. A reply adds an output state that
// holds while reply_stall_i is high. Non-listening segments end the scan at
// once and answer with RST|ACK if the checksum is good. Bad checksum segments
// end the scan at once with no reply. One segment is handled at a time.
// Reset is asynchronous and clears valid bits, states and scan registers.
module tcp_passive_handshake_engine_unit #(
  parameter int unsigned TableEntries = tph_pkg::TableEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic seg_valid_i,
  output logic seg_stall_o,
  input  logic [31:0] remote_ip_i,
  input  logic [31:0] local_ip_i,
  input  logic [15:0] remote_port_i,
  input  logic [15:0] local_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] peer_window_i,
  input  logic [7:0] flags_i,
  input  logic checksum_good_i,
  input  logic [31:0] initial_seq_i,
  output logic reply_valid_o,
  input  logic reply_stall_i,
  output logic [31:0] reply_src_ip_o,
  output logic [31:0] reply_dst_ip_o,
  output logic [15:0] reply_src_port_o,
  output logic [15:0] reply_dst_port_o,
  output logic [31:0] reply_seq_o,
  output logic [31:0] reply_ack_o,
  output logic [7:0] reply_flags_o,
  output logic [15:0] reply_window_o,
  output logic [2:0] new_state_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tph_pkg::*;

  logic [15:0] listen_port_q;
  logic listen_enable_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes always taken; only legal while idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_port_q <= ListenPortRst;
      listen_enable_q <= ListenEnableRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgListenPort: listen_port_q <= cfg_data_i;
        CfgListenEnable: listen_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tph_ctrl u_ctrl (
    .clk_i, .rst_ni, .seg_valid_i, .seg_stall_o, .reply_valid_o, .reply_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  tph_datapath #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .listen_port_i(listen_port_q), .listen_enable_i(listen_enable_q),
    .remote_ip_i, .local_ip_i, .remote_port_i, .local_port_i, .seq_number_i,
    .ack_number_i, .peer_window_i, .flags_i, .checksum_good_i, .initial_seq_i,
    .reply_src_ip_o, .reply_dst_ip_o, .reply_src_port_o, .reply_dst_port_o,
    .reply_seq_o, .reply_ack_o, .reply_flags_o, .reply_window_o, .new_state_o
  );
endmodule

// ----- rtl/core/tph_checker.sv -----
// Port-level checker for the handshake engine, bound to the top level
`include "tcp_passive_handshake_engine_unit_macros.svh"
module tph_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic seg_valid_i,
  input logic seg_stall_o,
  input logic reply_valid_o,
  input logic reply_stall_i,
  input logic [7:0] reply_flags_o,
  input logic [2:0] new_state_o
);
  import tph_pkg::*;
  `TPH_ASSERT(a_one_at_a_time, clk_i, rst_ni, reply_valid_o |-> seg_stall_o)
  `TPH_ASSERT(a_accept_blocks, clk_i, rst_ni,
    (seg_valid_i && !seg_stall_o) |=> seg_stall_o)
  `TPH_ASSERT(a_reply_hold, clk_i, rst_ni,
    (reply_valid_o && reply_stall_i) |=> (reply_valid_o && $stable(reply_flags_o)))
  `TPH_ASSERT(a_rst_closed, clk_i, rst_ni,
    (reply_valid_o && reply_flags_o == (FlRst | FlAck)) |-> new_state_o == StClosed)
  `TPH_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !reply_valid_o)
endmodule

bind tcp_passive_handshake_engine_unit tph_checker u_tph_checker (
  .clk_i, .rst_ni, .seg_valid_i, .seg_stall_o, .reply_valid_o, .reply_stall_i,
  .reply_flags_o, .new_state_o
);
